// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, ignored while reset is asserted
`define BPA_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("assertion failed");

// concurrent check, active during reset too
`define BPA_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("assertion failed");

`endif

// ===== sv/bpa_pkg.sv =====
package bpa_pkg;

  localparam int WORD_BITS = 64;
  localparam int MAX_LEVELS = 12;
  localparam int ORDER_W = 3;
  localparam int PAGE_W = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic              command;
    logic [ORDER_W-1:0] order;
    logic [PAGE_W-1:0] page_number;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] page_number_res;
  } out_item_t;

endpackage

// ===== sv/buddy_page_allocator_core.sv =====
// Buddy page allocator. One command beat is taken when start is high and busy is low; its
// single result comes back later as a one-cycle out_valid strobe that must be taken at once.
// After reset the free-mark memory is swept to zero, one word a cycle (2032 words at the
// default sizes), with busy high. An allocate command scans the bitmap words, each a word
// read and then a priority encode, from the asked order upward; it then splits each level
// below the level where a free block turned up, each a word read and then a write, and
// returns the result. A release reads and writes each level it visits while merging. A
// refused command (order too large, block past the end) answers straight from idle. The
// memory has a single read port and a single write port.
module buddy_page_allocator_core #(
  parameter int PAGE_COUNT = 65536,
  parameter int LEVELS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bpa_pkg::in_item_t  in_item,
  output logic               out_valid,
  output bpa_pkg::out_item_t out_item
);

  import bpa_pkg::*;

  function automatic int lvl_len(int k);
    return (PAGE_COUNT + (1 << k) - 1) >> k;
  endfunction

  function automatic int lvl_words(int k);
    return (lvl_len(k) + 63) >> 6;
  endfunction

  function automatic int lvl_base(int k);
    int s;
    s = 0;
    for (int j = 0; j < k; j++) begin
      s += lvl_words(j);
    end
    return s;
  endfunction

  localparam int DEPTH = lvl_base(LEVELS);
  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(PAGE_COUNT) + 1;
  localparam int WW = IW - 6;
  localparam int LW = $clog2(LEVELS);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_CLEAR    = 8'b0000_0010,
    ST_SCAN_RD  = 8'b0000_0100,
    ST_SCAN_CHK = 8'b0000_1000,
    ST_SPLIT_RD = 8'b0001_0000,
    ST_SPLIT_WR = 8'b0010_0000,
    ST_REL_RD   = 8'b0100_0000,
    ST_REL_WR   = 8'b1000_0000
  } state_t;

  logic [AW-1:0] base_tab [LEVELS];
  logic [IW-1:0] len_tab [LEVELS];
  logic [WW-1:0] words_tab [LEVELS];

  for (genvar g = 0; g < LEVELS; g++) begin : g_tab
    assign base_tab[g] = AW'(lvl_base(g));
    assign len_tab[g] = IW'(lvl_len(g));
    assign words_tab[g] = WW'(lvl_words(g));
  end

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [LW-1:0] order_r, order_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;
  logic          re;
  logic [AW-1:0] cur_addr;
  logic [63:0]   rd;
  logic [5:0]    ffs_pos;

  logic [31:0]   rel_idx;
  logic [31:0]   rel_end;
  logic          order_bad;
  logic [WW-1:0] word_inc;
  logic [IW-1:0] found_idx;
  logic [63:0]   bit_m;
  logic [63:0]   pair_m;
  logic          right_ok;
  logic          buddy_free;
  logic          lvl_top;
  logic          lvl_at_order;
  logic [IW-1:0] res_idx;
  logic [31:0]   res_page;

  bpa_mark_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (WORD_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(cur_addr),
    .rdata(rd)
  );

  bpa_ffs u_ffs (
    .word(rd),
    .pos (ffs_pos)
  );

  assign cur_addr = base_tab[lvl_r] + AW'(idx_r[IW-1:6]);
  assign rel_idx = 32'(in_item.page_number) >> in_item.order;
  assign rel_end = (rel_idx << in_item.order) + (32'd1 << in_item.order);
  assign order_bad = 32'(in_item.order) >= LEVELS;
  assign word_inc = idx_r[IW-1:6] + 1'b1;
  assign found_idx = {idx_r[IW-1:6], ffs_pos};
  assign bit_m = 64'd1 << idx_r[5:0];
  assign pair_m = 64'd3 << {idx_r[5:1], 1'b0};
  assign right_ok = (idx_r + 1'b1) < len_tab[lvl_r];
  assign buddy_free = rd[idx_r[5:0] ^ 6'd1];
  assign lvl_top = lvl_r == LW'(LEVELS - 1);
  assign lvl_at_order = lvl_r == order_r;
  assign res_page = 32'(res_idx) << order_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    lvl_nxt = lvl_r;
    order_nxt = order_r;
    idx_nxt = idx_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    we = 1'b0;
    waddr = cur_addr;
    wdata = rd;
    re = 1'b0;
    res_idx = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_nxt = '0;
          if (order_bad) begin
            out_valid_nxt = 1'b1;
          end else if (in_item.command == CMD_ALLOC) begin
            lvl_nxt = LW'(in_item.order);
            order_nxt = LW'(in_item.order);
            idx_nxt = '0;
            state_nxt = ST_SCAN_RD;
          end else if (rel_end > 32'(PAGE_COUNT)) begin
            out_valid_nxt = 1'b1;
          end else begin
            lvl_nxt = LW'(in_item.order);
            order_nxt = LW'(in_item.order);
            idx_nxt = IW'(rel_idx);
            state_nxt = ST_REL_RD;
          end
        end
      end
      ST_CLEAR: begin
        we = 1'b1;
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        re = 1'b1;
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (rd != '0) begin
          we = 1'b1;
          wdata = rd & ~(64'd1 << ffs_pos);
          res_idx = found_idx;
          if (lvl_at_order) begin
            out_valid_nxt = 1'b1;
            out_nxt.ok = 1'b1;
            out_nxt.page_number_res = res_page[PAGE_W-1:0];
            state_nxt = ST_IDLE;
          end else begin
            lvl_nxt = lvl_r - 1'b1;
            idx_nxt = {found_idx[IW-2:0], 1'b0};
            state_nxt = ST_SPLIT_RD;
          end
        end else if (word_inc == words_tab[lvl_r]) begin
          if (lvl_top) begin
            out_valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            lvl_nxt = lvl_r + 1'b1;
            idx_nxt = '0;
            state_nxt = ST_SCAN_RD;
          end
        end else begin
          idx_nxt = {word_inc, 6'd0};
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SPLIT_RD: begin
        re = 1'b1;
        state_nxt = ST_SPLIT_WR;
      end
      ST_SPLIT_WR: begin
        we = 1'b1;
        wdata = (rd & ~bit_m) | (right_ok ? (bit_m << 1) : 64'd0);
        if (lvl_at_order) begin
          out_valid_nxt = 1'b1;
          out_nxt.ok = 1'b1;
          out_nxt.page_number_res = res_page[PAGE_W-1:0];
          state_nxt = ST_IDLE;
        end else begin
          lvl_nxt = lvl_r - 1'b1;
          idx_nxt = {idx_r[IW-2:0], 1'b0};
          state_nxt = ST_SPLIT_RD;
        end
      end
      ST_REL_RD: begin
        re = 1'b1;
        state_nxt = ST_REL_WR;
      end
      ST_REL_WR: begin
        we = 1'b1;
        if (buddy_free && !lvl_top) begin
          wdata = rd & ~pair_m;
          lvl_nxt = lvl_r + 1'b1;
          idx_nxt = idx_r >> 1;
          state_nxt = ST_REL_RD;
        end else begin
          wdata = rd | bit_m;
          out_valid_nxt = 1'b1;
          out_nxt.ok = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
    order_r <= order_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign busy = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_item = out_r;

endmodule

// ===== sv/bpa_mark_ram.sv =====
module bpa_mark_ram #(
  parameter int DEPTH = 2032,
  parameter int AW = 11,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bpa_ffs.sv =====
module bpa_ffs (
  input  logic [63:0] word,
  output logic [5:0]  pos
);

  // lowest set bit
  always_comb begin
    pos = 6'd0;
    for (int b = 63; b >= 0; b--) begin
      if (word[b]) begin
        pos = 6'(b);
      end
    end
  end

endmodule

// ===== sv/bpa_checker.sv =====
`include "assert_macros.svh"

module bpa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input bpa_pkg::in_item_t  in_item,
  input logic               out_valid,
  input bpa_pkg::out_item_t out_item
);

  import bpa_pkg::*;

  // no strobe in the cycle after a reset edge
  `BPA_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid)
  // a failed beat carries no page
  `BPA_ASSERT(a_fail_zero, clk, rst_n, out_valid && !out_item.ok |-> out_item.page_number_res == '0)
  // a result leaves the block ready for the next command
  `BPA_ASSERT(a_done_idle, clk, rst_n, out_valid |-> !busy)
  // an accepted command either starts work or answers at once
  `BPA_ASSERT(a_take, clk, rst_n, start && !busy |=> busy || out_valid)

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (.*);
